>>> rtl/core/uscu_pkg.sv
// ----------------------------------------------------------------------------
// uscu_pkg
// Shared types, constants and helper functions of the send-side congestion
// update unit
// ----------------------------------------------------------------------------
`default_nettype none

package uscu_pkg;

	// largest send data size in bytes; window growth divides by it, so it
	// stays a power of two in this implementation
	localparam int unsigned MAX_DATA_SIZE  = 1024;
	localparam int unsigned MDS_SHIFT      = $clog2(MAX_DATA_SIZE);
	localparam int unsigned SYNC_PERIOD_US = 10000;

	// register reset values
	localparam logic [15:0] MIN_DATA_SIZE_RST = 16'd512;
	localparam logic [15:0] MIN_WINDOW_RST    = 16'd16;
	localparam logic [15:0] MAX_WINDOW_RST    = 16'd4096;
	localparam logic [7:0]  LIMIT_WIRELESS_RST = 8'd1;
	localparam logic [7:0]  LIMIT_E1_RST       = 8'd2;
	localparam logic [7:0]  LIMIT_GIGE_RST     = 8'd3;

	// allowed-loss levels per link class
	localparam logic [2:0] LOSS_WIRELESS = 3'd5;
	localparam logic [2:0] LOSS_E1       = 3'd2;
	localparam logic [2:0] LOSS_GIGE     = 3'd1;

	// floor(x/10) as multiply by ceil(2^23/10) and shift, exact below 2^22
	localparam logic [19:0] RECIP10       = 20'd838861;
	localparam int unsigned RECIP10_SHIFT = 23;

	typedef enum logic [1:0] {
		CMD_ACK     = 2'd0,
		CMD_ACK2    = 2'd1,
		CMD_NAK     = 2'd2,
		CMD_TIMEOUT = 2'd3
	} uscu_cmd_t;

	typedef enum logic [2:0] {
		REG_MIN_DATA_SIZE  = 3'd0,
		REG_MIN_WINDOW     = 3'd1,
		REG_MAX_WINDOW     = 3'd2,
		REG_PEER_CLASS     = 3'd3,
		REG_LOCAL_CLASS    = 3'd4,
		REG_LIMIT_WIRELESS = 3'd5,
		REG_LIMIT_E1       = 3'd6,
		REG_LIMIT_GIGE     = 3'd7
	} uscu_reg_t;

	typedef struct packed {
		uscu_cmd_t   cmd;
		logic [31:0] rtt_us;
		logic [31:0] rtt_var_us;
		logic [31:0] avail_buffer_bytes;
		logic [31:0] peer_rate;
		logic [31:0] peer_capacity;
	} uscu_item_t;

	typedef struct packed {
		logic [31:0] rtt_now;
		logic [31:0] rtt_var_now;
		logic [34:0] ack_delay_us;
		logic [31:0] recv_rate_now;
		logic [31:0] capacity_now;
		logic [15:0] window_now;
		logic [15:0] data_size_now;
		logic [15:0] loss_events;
	} uscu_res_t;

	typedef struct packed {
		logic [31:0] rtt;
		logic [31:0] rtt_var;
		logic [31:0] recv_rate;
		logic [31:0] capacity;
		logic [15:0] window;
		logic [15:0] data_size;
		logic [15:0] nak_cnt;
		logic [15:0] tmo_cnt;
	} uscu_state_t;

	// settings the update logic reads from the register block
	typedef struct packed {
		logic [15:0] min_data_size;
		logic [15:0] min_window;
		logic [15:0] max_window;
		logic [2:0]  allowed_loss;
	} uscu_cfg_t;

	// floor(9x/10) of a 16-bit value
	function automatic logic [15:0] nine_tenths(input logic [15:0] x);
		logic [19:0] x9;
		logic [39:0] prod;
		x9   = {1'b0, x, 3'b000} + {4'b0000, x};
		prod = {20'd0, x9} * {20'd0, RECIP10};
		return prod[RECIP10_SHIFT +: 16];
	endfunction

	// 4*rtt + var + sync period, 35 bits
	function automatic logic [34:0] ack_delay(input logic [31:0] rtt,
			input logic [31:0] rtt_var);
		return {1'b0, rtt, 2'b00} + {3'b000, rtt_var} + 35'(SYNC_PERIOD_US);
	endfunction

endpackage

`default_nettype wire

>>> rtl/core/uscu_evt_if.sv
// ----------------------------------------------------------------------------
// uscu_evt_if
// Event channel: one control event per beat
// ----------------------------------------------------------------------------
`default_nettype none

interface uscu_evt_if;
	import uscu_pkg::*;

	logic        valid;
	logic        ready;
	uscu_cmd_t   cmd;
	logic [31:0] rtt_us;
	logic [31:0] rtt_var_us;
	logic [31:0] avail_buffer_bytes;
	logic [31:0] peer_rate;
	logic [31:0] peer_capacity;

	modport source (
		output valid, cmd, rtt_us, rtt_var_us, avail_buffer_bytes, peer_rate,
			peer_capacity,
		input  ready
	);

	modport sink (
		input  valid, cmd, rtt_us, rtt_var_us, avail_buffer_bytes, peer_rate,
			peer_capacity,
		output ready
	);

endinterface

`default_nettype wire

>>> rtl/core/uscu_upd_if.sv
// ----------------------------------------------------------------------------
// uscu_upd_if
// Update channel: congestion state after one event per beat
// ----------------------------------------------------------------------------
`default_nettype none

interface uscu_upd_if;

	logic        valid;
	logic        ready;
	logic [31:0] rtt_now;
	logic [31:0] rtt_var_now;
	logic [34:0] ack_delay_us;
	logic [31:0] recv_rate_now;
	logic [31:0] capacity_now;
	logic [15:0] window_now;
	logic [15:0] data_size_now;
	logic [15:0] loss_events;

	modport source (
		output valid, rtt_now, rtt_var_now, ack_delay_us, recv_rate_now,
			capacity_now, window_now, data_size_now, loss_events,
		input  ready
	);

	modport sink (
		input  valid, rtt_now, rtt_var_now, ack_delay_us, recv_rate_now,
			capacity_now, window_now, data_size_now, loss_events,
		output ready
	);

endinterface

`default_nettype wire

>>> rtl/core/uscu_cfg.sv
// ----------------------------------------------------------------------------
// uscu_cfg
// Configuration registers and allowed-loss level from the link classes
// ----------------------------------------------------------------------------
`default_nettype none

module uscu_cfg (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                cfg_we,
	input  wire uscu_pkg::uscu_reg_t cfg_idx,
	input  wire logic [15:0]         cfg_wdata,
	output uscu_pkg::uscu_cfg_t      cfg
);
	import uscu_pkg::*;

	logic [15:0] min_dsz_q;
	logic [15:0] min_wnd_q;
	logic [15:0] max_wnd_q;
	logic [7:0]  peer_cls_q;
	logic [7:0]  local_cls_q;
	logic [7:0]  lim_wl_q;
	logic [7:0]  lim_e1_q;
	logic [7:0]  lim_ge_q;
	logic [2:0]  allowed_q;
	logic [7:0]  worst;
	logic [2:0]  allowed_nxt;

	// lesser class of the new peer value and the local one
	always_comb begin
		worst = (cfg_wdata[7:0] < local_cls_q) ? cfg_wdata[7:0] : local_cls_q;
		if (worst <= lim_wl_q) begin
			allowed_nxt = LOSS_WIRELESS;
		end else if (worst <= lim_e1_q) begin
			allowed_nxt = LOSS_E1;
		end else if (worst <= lim_ge_q) begin
			allowed_nxt = LOSS_GIGE;
		end else begin
			allowed_nxt = allowed_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_dsz_q   <= MIN_DATA_SIZE_RST;
			min_wnd_q   <= MIN_WINDOW_RST;
			max_wnd_q   <= MAX_WINDOW_RST;
			peer_cls_q  <= '0;
			local_cls_q <= '0;
			lim_wl_q    <= LIMIT_WIRELESS_RST;
			lim_e1_q    <= LIMIT_E1_RST;
			lim_ge_q    <= LIMIT_GIGE_RST;
			allowed_q   <= '0;
		end else if (cfg_we) begin
			case (cfg_idx)
				REG_MIN_DATA_SIZE:  min_dsz_q <= cfg_wdata;
				REG_MIN_WINDOW:     min_wnd_q <= cfg_wdata;
				REG_MAX_WINDOW:     max_wnd_q <= cfg_wdata;
				REG_PEER_CLASS: begin
					peer_cls_q <= cfg_wdata[7:0];
					allowed_q  <= allowed_nxt;
				end
				REG_LOCAL_CLASS:    local_cls_q <= cfg_wdata[7:0];
				REG_LIMIT_WIRELESS: lim_wl_q <= cfg_wdata[7:0];
				REG_LIMIT_E1:       lim_e1_q <= cfg_wdata[7:0];
				REG_LIMIT_GIGE:     lim_ge_q <= cfg_wdata[7:0];
				default: ;
			endcase
		end
	end

	assign cfg.min_data_size = min_dsz_q;
	assign cfg.min_window    = min_wnd_q;
	assign cfg.max_window    = max_wnd_q;
	assign cfg.allowed_loss  = allowed_q;

	// level only ever holds one of the class levels or its reset value
	a_level_legal: assert property (@(posedge clk) disable iff (!arst_n)
		allowed_q == '0 || allowed_q == LOSS_GIGE || allowed_q == LOSS_E1 ||
		allowed_q == LOSS_WIRELESS)
		else $error("allowed-loss level out of set");

	// level moves only on a peer class write
	a_level_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!(cfg_we && cfg_idx == REG_PEER_CLASS) |=> $stable(allowed_q))
		else $error("allowed-loss level changed without peer class write");

	// peer class register must track the written value
	a_peer_written: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_we && cfg_idx == REG_PEER_CLASS |=> peer_cls_q == $past(cfg_wdata[7:0]))
		else $error("peer class not written");

endmodule

`default_nettype wire

>>> rtl/core/uscu_update.sv
// ----------------------------------------------------------------------------
// uscu_update
// Next congestion state and result for one event
// ----------------------------------------------------------------------------
`default_nettype none

module uscu_update (
	input  wire uscu_pkg::uscu_item_t  item,
	input  wire uscu_pkg::uscu_state_t cur,
	input  wire uscu_pkg::uscu_cfg_t   cfg,
	output uscu_pkg::uscu_state_t      nxt,
	output uscu_pkg::uscu_res_t        res
);
	import uscu_pkg::*;

	localparam logic [16:0] MAX_DSZ = 17'(MAX_DATA_SIZE);

	// ack path
	logic [34:0] rate_sum;
	logic [34:0] cap_sum;
	logic [16:0] loss_sum;
	logic        over_loss;
	logic [15:0] dsz_dn;
	logic [16:0] dsz_up;
	logic [15:0] dsz_new;
	logic        grow_wnd;
	logic [32:0] wnd_inc;
	logic [33:0] wnd_sum;
	logic [15:0] wnd_dn;
	logic [15:0] wnd_new;
	// ack of ack path
	logic [31:0] sample;
	logic [31:0] diff;
	logic [31:0] rtt_t;
	logic [31:0] var_t;
	// result loss count
	logic [16:0] loss_out;

	always_comb begin
		rate_sum = {cur.recv_rate, 3'b000} - {3'b000, cur.recv_rate}
			+ {3'b000, item.peer_rate};
		cap_sum  = {cur.capacity, 3'b000} - {3'b000, cur.capacity}
			+ {3'b000, item.peer_capacity};

		loss_sum  = {1'b0, cur.nak_cnt} + {1'b0, cur.tmo_cnt};
		over_loss = loss_sum > {14'd0, cfg.allowed_loss};
		dsz_dn    = nine_tenths(cur.data_size);
		dsz_up    = {1'b0, cur.data_size} + {2'b00, cur.data_size[15:1]};
		if (over_loss) begin
			dsz_new = (dsz_dn < cfg.min_data_size) ? cfg.min_data_size : dsz_dn;
		end else begin
			dsz_new = (dsz_up > MAX_DSZ) ? MAX_DSZ[15:0] : dsz_up[15:0];
		end

		grow_wnd = item.avail_buffer_bytes > {13'd0, dsz_new, 3'b000};
		wnd_inc  = ({1'b0, item.avail_buffer_bytes} + 33'd1) >> MDS_SHIFT;
		wnd_sum  = {18'd0, cur.window} + {1'b0, wnd_inc};
		wnd_dn   = nine_tenths(cur.window);
		if (grow_wnd) begin
			wnd_new = (wnd_sum > {18'd0, cfg.max_window}) ? cfg.max_window
				: wnd_sum[15:0];
		end else begin
			wnd_new = (wnd_dn < cfg.min_window) ? cfg.min_window : wnd_dn;
		end

		sample = item.rtt_us;
		diff   = (sample < cur.rtt) ? (cur.rtt - sample) : (sample - cur.rtt);
		rtt_t  = {cur.rtt[28:0], 3'b000} - cur.rtt + sample;
		var_t  = {cur.rtt_var[30:0], 1'b0} + cur.rtt_var + diff;

		nxt = cur;
		case (item.cmd)
			CMD_ACK: begin
				nxt.rtt     = item.rtt_us;
				nxt.rtt_var = item.rtt_var_us;
				if (item.peer_rate != '0) begin
					nxt.recv_rate = rate_sum[34:3];
				end
				if (item.peer_capacity != '0) begin
					nxt.capacity = cap_sum[34:3];
				end
				nxt.data_size = dsz_new;
				nxt.window    = wnd_new;
				nxt.nak_cnt   = '0;
				nxt.tmo_cnt   = '0;
			end
			CMD_ACK2: begin
				nxt.rtt     = {3'b000, rtt_t[31:3]};
				nxt.rtt_var = {2'b00, var_t[31:2]};
			end
			CMD_NAK: begin
				if (cur.nak_cnt != '1) begin
					nxt.nak_cnt = cur.nak_cnt + 16'd1;
				end
			end
			CMD_TIMEOUT: begin
				if (cur.tmo_cnt != '1) begin
					nxt.tmo_cnt = cur.tmo_cnt + 16'd1;
				end
			end
			default: ;
		endcase

		loss_out = {1'b0, nxt.nak_cnt} + {1'b0, nxt.tmo_cnt};

		res.rtt_now       = nxt.rtt;
		res.rtt_var_now   = nxt.rtt_var;
		res.ack_delay_us  = ack_delay(nxt.rtt, nxt.rtt_var);
		res.recv_rate_now = nxt.recv_rate;
		res.capacity_now  = nxt.capacity;
		res.window_now    = nxt.window;
		res.data_size_now = nxt.data_size;
		res.loss_events   = loss_out[16] ? 16'hFFFF : loss_out[15:0];
	end

endmodule

`default_nettype wire

>>> rtl/core/udt_send_congestion_update_unit.sv
// ----------------------------------------------------------------------------
// udt_send_congestion_update_unit
// Send-side congestion state of a reliable transport, advanced per control
// event
// ----------------------------------------------------------------------------
// usage
//  - evt carries one control event per beat (ack, ack of ack, nak, send
//    timeout) with the rtt, variance, buffer, peer rate and capacity fields
//  - upd returns one beat per event with the congestion state after it:
//    rtt, variance, ack delay, rate, capacity, window, data size and loss count
//  - cfg_we/cfg_idx/cfg_wdata write the clamp and link class registers; a
//    peer class write recomputes the allowed-loss level; write only while idle
//  - an event passes the event register, then the result register, to upd
//  - throughput: one event per cycle unless upd stalls; state registers close
//    a loop through the update logic, so each event sees the previous result
//  - an event register and a result register part the channels: evt stays
//    ready while a finished result waits, as long as the event stage is free
//  - when upd stalls, the result holds and at most one more event is taken
//  - reset clears rtt, variance, rate, capacity and loss counters, loads the
//    window with 16 and the data size with 512, and returns the configuration
//    registers to their defaults
// ----------------------------------------------------------------------------
`default_nettype none

module udt_send_congestion_update_unit (
	input  wire logic                clk,
	input  wire logic                arst_n,
	uscu_evt_if.sink                 evt,
	uscu_upd_if.source               upd,
	input  wire logic                cfg_we,
	input  wire uscu_pkg::uscu_reg_t cfg_idx,
	input  wire logic [15:0]         cfg_wdata
);
	import uscu_pkg::*;

	uscu_cfg_t   cfg;
	uscu_item_t  evt_in;
	uscu_item_t  evt_s1;
	logic        vld_s1;
	uscu_res_t   out_s2;
	logic        vld_s2;
	uscu_state_t state_q;
	uscu_state_t state_nxt;
	uscu_res_t   res_nxt;
	logic        advance;
	logic        evt_fire;

	// register block
	uscu_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_idx   (cfg_idx),
		.cfg_wdata (cfg_wdata),
		.cfg       (cfg)
	);

	// next state from the staged event and current state
	uscu_update u_update (
		.item (evt_s1),
		.cur  (state_q),
		.cfg  (cfg),
		.nxt  (state_nxt),
		.res  (res_nxt)
	);

	// result stage frees when empty or taken
	assign advance   = !vld_s2 || upd.ready;
	assign evt.ready = !vld_s1 || advance;
	assign evt_fire  = evt.valid && evt.ready;

	assign evt_in.cmd                = evt.cmd;
	assign evt_in.rtt_us             = evt.rtt_us;
	assign evt_in.rtt_var_us         = evt.rtt_var_us;
	assign evt_in.avail_buffer_bytes = evt.avail_buffer_bytes;
	assign evt_in.peer_rate          = evt.peer_rate;
	assign evt_in.peer_capacity      = evt.peer_capacity;

	// event stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (evt.ready) begin
			vld_s1 <= evt.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (evt_fire) begin
			evt_s1 <= evt_in;
		end
	end

	// result stage valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (advance) begin
			vld_s2 <= vld_s1;
		end
	end

	// result payload, loaded together with the state
	always_ff @(posedge clk) begin
		if (advance && vld_s1) begin
			out_s2 <= res_nxt;
		end
	end

	// congestion state, one update per event leaving the event stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '{
				rtt:       '0,
				rtt_var:   '0,
				recv_rate: '0,
				capacity:  '0,
				window:    MIN_WINDOW_RST,
				data_size: MIN_DATA_SIZE_RST,
				nak_cnt:   '0,
				tmo_cnt:   '0
			};
		end else if (advance && vld_s1) begin
			state_q <= state_nxt;
		end
	end

	assign upd.valid         = vld_s2;
	assign upd.rtt_now       = out_s2.rtt_now;
	assign upd.rtt_var_now   = out_s2.rtt_var_now;
	assign upd.ack_delay_us  = out_s2.ack_delay_us;
	assign upd.recv_rate_now = out_s2.recv_rate_now;
	assign upd.capacity_now  = out_s2.capacity_now;
	assign upd.window_now    = out_s2.window_now;
	assign upd.data_size_now = out_s2.data_size_now;
	assign upd.loss_events   = out_s2.loss_events;

	// staged event must not be overwritten while the result stage is blocked
	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s1 && !advance |=> vld_s1 && $stable(evt_s1))
		else $error("event stage lost while stalled");

	// an ack clears the loss count seen in its result
	a_ack_clears: assert property (@(posedge clk) disable iff (!arst_n)
		advance && vld_s1 && evt_s1.cmd == CMD_ACK |=> out_s2.loss_events == '0)
		else $error("loss count not cleared by ack");

	// ack delay in a result agrees with its rtt and variance
	a_delay: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s2 |-> out_s2.ack_delay_us == ack_delay(out_s2.rtt_now,
			out_s2.rtt_var_now))
		else $error("ack delay inconsistent with rtt");

	// a result appears only from a staged event
	a_s2_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(vld_s2) |-> $past(vld_s1))
		else $error("result without event");

endmodule

`default_nettype wire
